@@ rtl/cdq_pkg.sv @@
// Package: shared constants, codes and control/status structs of the circular deque.
`timescale 1ns / 1ps

package cdq_pkg;

    // Storage geometry
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CMD_W      = 2;
    localparam int VAL_W      = 32;
    localparam int STATUS_W   = 2;

    // Word commands
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_POP_FRONT  = 2'd1,
        CMD_PUSH_BACK  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } cmd_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_DONE = 2'd2
    } state_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic    load;
        logic    exec;
        logic    push_front;
        logic    pop_front;
        logic    push_back;
        logic    pop_back;
        status_t st_code;
    } dp_ctrl_t;

    // Datapath -> controller status
    typedef struct packed {
        cmd_t cmd;
        logic full;
        logic empty;
    } dp_stat_t;

endpackage

@@ rtl/circular_deque.sv @@
// Top level: double-ended queue in a fixed circular store, controller plus datapath.
`timescale 1ns / 1ps

// A word (cmd, push_value) is taken when start is high and busy is low. Each
// word passes through the execute state, where busy is high and the store
// does its single registered read or write while the front/back indices and
// the entry count move, then the done state, in which done strobes with
// pop_value, status and is_empty. A new start is taken during that done
// cycle, so a new word is never taken before the last reaches done. The
// receiver cannot stall: results are valid only in the cycle done is high.
// Capacity is 16 entries; a push when full is dropped with status 2, a pop
// when empty returns -1 with status 1, and pop_value is -1 for every push.

module circular_deque (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [cdq_pkg::CMD_W-1:0]         cmd,
    input  logic signed [cdq_pkg::VAL_W-1:0]  push_value,
    output logic                              busy,
    output logic                              done,
    output logic signed [cdq_pkg::VAL_W-1:0]  pop_value,
    output logic [cdq_pkg::STATUS_W-1:0]      status,
    output logic                              is_empty
);
    import cdq_pkg::*;

    dp_ctrl_t dp_ctrl;
    dp_stat_t dp_stat;

    // Sequencer
    cdq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .dp_stat (dp_stat),
        .dp_ctrl (dp_ctrl),
        .busy    (busy),
        .done    (done)
    );

    // Storage and result datapath
    cdq_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .dp_ctrl    (dp_ctrl),
        .cmd        (cmd),
        .push_value (push_value),
        .dp_stat    (dp_stat),
        .pop_value  (pop_value),
        .status     (status),
        .is_empty   (is_empty)
    );

endmodule

@@ rtl/cdq_ctrl.sv @@
// Controller: sequences one deque word through load, execute and result strobe.
`timescale 1ns / 1ps

module cdq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  cdq_pkg::dp_stat_t dp_stat,
    output cdq_pkg::dp_ctrl_t dp_ctrl,
    output logic              busy,
    output logic              done
);
    import cdq_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        dp_ctrl    = '0;
        dp_ctrl.st_code = ST_OK;
        busy = 1'b0;
        done = 1'b0;
        unique case (state_reg)
            S_IDLE, S_DONE:
            begin
                done = (state_reg == S_DONE);
                if (start)
                begin
                    dp_ctrl.load = 1'b1;
                    state_next   = S_EXEC;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EXEC:
            begin
                busy         = 1'b1;
                dp_ctrl.exec = 1'b1;
                state_next   = S_DONE;
                unique case (dp_stat.cmd)
                    CMD_PUSH_FRONT, CMD_PUSH_BACK:
                    begin
                        if (dp_stat.full)
                        begin
                            dp_ctrl.st_code = ST_FULL;
                        end
                        else
                        begin
                            dp_ctrl.push_front = (dp_stat.cmd == CMD_PUSH_FRONT);
                            dp_ctrl.push_back  = (dp_stat.cmd == CMD_PUSH_BACK);
                        end
                    end
                    CMD_POP_FRONT, CMD_POP_BACK:
                    begin
                        if (dp_stat.empty)
                        begin
                            dp_ctrl.st_code = ST_EMPTY;
                        end
                        else
                        begin
                            dp_ctrl.pop_front = (dp_stat.cmd == CMD_POP_FRONT);
                            dp_ctrl.pop_back  = (dp_stat.cmd == CMD_POP_BACK);
                        end
                    end
                    default:
                    begin
                        dp_ctrl.st_code = ST_OK;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // At most one storage operation per execute cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({dp_ctrl.push_front, dp_ctrl.pop_front, dp_ctrl.push_back, dp_ctrl.pop_back}))
        else $error("cdq_ctrl: more than one deque operation at once");

    // Every execute cycle is followed by exactly one result strobe
    assert property (@(posedge clk) disable iff (!rst_n) busy |=> done)
        else $error("cdq_ctrl: execute not followed by result");

endmodule

@@ rtl/cdq_dp.sv @@
// Datapath: entry store, front/back indices, entry count and result registers.
`timescale 1ns / 1ps

module cdq_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cdq_pkg::dp_ctrl_t             dp_ctrl,
    input  logic [cdq_pkg::CMD_W-1:0]     cmd,
    input  logic signed [cdq_pkg::VAL_W-1:0] push_value,
    output cdq_pkg::dp_stat_t             dp_stat,
    output logic signed [cdq_pkg::VAL_W-1:0] pop_value,
    output logic [cdq_pkg::STATUS_W-1:0]  status,
    output logic                          is_empty
);
    import cdq_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    cmd_t                  cmd_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    logic [IDX_W-1:0]      front_reg, front_next;
    logic [IDX_W-1:0]      back_reg, back_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic                  pop_ok_reg;
    status_t               status_reg;

    logic [63:0]           push_wide;
    logic [63:0]           pop_wide;
    logic [IDX_W-1:0]      front_dec, front_inc, back_dec, back_inc;
    logic [IDX_W-1:0]      wr_addr, rd_addr;
    logic                  wr_en, rd_en;

    // Word capture, push value cut to storage width
    assign push_wide = 64'(push_value);

    always_ff @(posedge clk)
    begin
        if (dp_ctrl.load)
        begin
            cmd_reg   <= cmd_t'(cmd);
            value_reg <= push_wide[DATA_WIDTH-1:0];
        end
    end

    // Wrapping index neighbors
    always_comb
    begin
        front_dec = (front_reg == '0) ? LAST_IDX : front_reg - IDX_W'(1);
        front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + IDX_W'(1);
        back_dec  = (back_reg == '0) ? LAST_IDX : back_reg - IDX_W'(1);
        back_inc  = (back_reg == LAST_IDX) ? '0 : back_reg + IDX_W'(1);
    end

    // Index and count update
    always_comb
    begin
        front_next = front_reg;
        back_next  = back_reg;
        count_next = count_reg;
        if (dp_ctrl.push_front)
        begin
            front_next = front_dec;
            count_next = count_reg + CNT_W'(1);
        end
        if (dp_ctrl.push_back)
        begin
            back_next  = back_inc;
            count_next = count_reg + CNT_W'(1);
        end
        if (dp_ctrl.pop_front)
        begin
            front_next = front_inc;
            count_next = count_reg - CNT_W'(1);
        end
        if (dp_ctrl.pop_back)
        begin
            back_next  = back_dec;
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            back_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
        end
    end

    // Store port addresses
    assign wr_en   = dp_ctrl.push_front | dp_ctrl.push_back;
    assign wr_addr = dp_ctrl.push_front ? front_dec : back_reg;
    assign rd_en   = dp_ctrl.pop_front | dp_ctrl.pop_back;
    assign rd_addr = dp_ctrl.pop_front ? front_reg : back_dec;

    // Entry store write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value_reg;
        end
    end

    // Entry store registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop_ok_reg <= 1'b0;
            status_reg <= ST_OK;
        end
        else if (dp_ctrl.exec)
        begin
            pop_ok_reg <= rd_en;
            status_reg <= dp_ctrl.st_code;
        end
    end

    // Result ports; pop data sign-extended from storage width
    assign pop_wide  = 64'($signed(rd_data_reg));
    assign pop_value = pop_ok_reg ? pop_wide[VAL_W-1:0] : '1;
    assign status    = status_reg;
    assign is_empty  = (count_reg == '0);

    // Status to controller
    assign dp_stat.cmd   = cmd_reg;
    assign dp_stat.full  = (count_reg == FULL_CNT);
    assign dp_stat.empty = (count_reg == '0);

    // Count stays within capacity
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FULL_CNT)
        else $error("cdq_dp: entry count above capacity");

    // Back index equals front index plus the count, modulo depth
    assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W'(front_reg) + count_reg == CNT_W'(back_reg)) ||
        (CNT_W'(front_reg) + count_reg == CNT_W'(back_reg) + FULL_CNT))
        else $error("cdq_dp: front/back/count out of step");

endmodule
